FILE: src/pedal_motor_drive_controller_defines.svh
// Assertion macros shared by the pedal motor drive controller sources
`ifndef PEDAL_MOTOR_DRIVE_CONTROLLER_DEFINES_SVH
`define PEDAL_MOTOR_DRIVE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define PMDC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PMDC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define PMDC_ASSERT(name, prop, msg)
`define PMDC_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

FILE: src/pmdc_pkg.sv
// Shared constants, codes and types of the pedal motor drive controller
package pmdc_pkg;

	localparam int LEVEL_BITS = 16;
	localparam int PROD_BITS  = 2 * LEVEL_BITS;
	localparam int CNT_W      = $clog2(LEVEL_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEVEL_BITS - 1);
	localparam int CFG_IDX_W  = 3;

	localparam logic [LEVEL_BITS-1:0] RST_PEDAL_THRESHOLD   = LEVEL_BITS'(1311);
	localparam logic [LEVEL_BITS-1:0] RST_PEDAL_FULL_SCALE  = LEVEL_BITS'(65535);
	localparam logic [LEVEL_BITS-1:0] RST_CURRENT_SCALE     = LEVEL_BITS'(45219);
	localparam logic [LEVEL_BITS-1:0] RST_SMOOTHING_FACTOR  = LEVEL_BITS'(16384);
	localparam logic [LEVEL_BITS-1:0] RST_REGEN_SCALE       = LEVEL_BITS'(32768);
	localparam logic [LEVEL_BITS-1:0] RST_SWITCHING_CURRENT = LEVEL_BITS'(655);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEDAL_THRESHOLD   = 3'd0,
		REG_PEDAL_FULL_SCALE  = 3'd1,
		REG_CURRENT_SCALE     = 3'd2,
		REG_SMOOTHING_FACTOR  = 3'd3,
		REG_REGEN_SCALE       = 3'd4,
		REG_SWITCHING_CURRENT = 3'd5
	} cfg_reg_e;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ACCEL = 2'd1,
		MODE_REGEN = 2'd2,
		MODE_MECH  = 2'd3
	} mode_e;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_SETTING   = 2'd1,
		PH_RESETTING = 2'd2
	} phase_e;

	typedef enum logic [1:0] {
		VEL_ZERO = 2'd0,
		VEL_FWD  = 2'd1,
		VEL_REV  = 2'd2
	} vel_e;

	// where the new current comes from
	typedef enum logic [1:0] {
		CUR_ZERO  = 2'd0,
		CUR_RAW   = 2'd1,
		CUR_PEDAL = 2'd2,
		CUR_DECAY = 2'd3
	} cur_sel_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PMUL,
		ST_PDIV,
		ST_TGT,
		ST_RMUL,
		ST_SMOOTH,
		ST_SMUL,
		ST_FIN
	} state_e;

	typedef struct packed {
		mode_e                 mode;
		logic                  flag;
		phase_e                phase;
		vel_e                  vel;
		logic                  pulse;
		cur_sel_e              cur_sel;
		logic [LEVEL_BITS-1:0] pedal;
		logic                  use_regen;
		logic                  decay_chk;
	} dec_t;

	typedef struct packed {
		logic                  go;
		logic [LEVEL_BITS-1:0] a;
		logic [LEVEL_BITS-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                  go;
		logic [PROD_BITS-1:0]  dividend;
		logic [LEVEL_BITS-1:0] den;
	} div_req_t;

endpackage

FILE: src/pedal_motor_drive_controller.sv
// Pedal motor drive controller top level: mode machine, sequencer and state
// Usage:
//   Input channel (in_valid/in_stall) takes one word per control tick: both
//   pedal levels, direction, brake, reset button and battery permissions.
//   Output channel (out_valid/out_stall) returns one word per tick: motor
//   current, velocity choice, drive mode and reset pulse.
//   Config channel (cfg_valid/cfg_ready) writes the six tuning registers;
//   cfg_ready is always high. Write only while no tick is in flight.
// Timing:
//   One tick is worked at a time. A tick with no current math passes from the
//   decide state straight to the finish state. A pedal tick runs the bit-serial
//   multiplier up to three times and the serial divider at most once; these
//   serial units set how long a pedal tick takes.
// Reset:
//   arst_n clears mode, current, switch flag and reset phase, and loads the
//   register defaults. No clearing pass is needed.
// Stall:
//   A finished word waits in the output register; the next tick is accepted
//   and worked, and commits only once that word has been taken.
`include "pedal_motor_drive_controller_defines.svh"
module pedal_motor_drive_controller
	import pmdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [LEVEL_BITS-1:0] accel_pedal,
	input  logic [LEVEL_BITS-1:0] regen_pedal,
	input  logic [1:0]            direction_bits,
	input  logic                  brake_line,
	input  logic                  reset_line,
	input  logic                  allow_charge,
	input  logic                  allow_discharge,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LEVEL_BITS-1:0] motor_current,
	output logic [1:0]            velocity_select,
	output logic [1:0]            drive_mode,
	output logic                  send_reset,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LEVEL_BITS-1:0] cfg_data
);

	state_e state_q, state_d;

	// tuning registers
	logic [LEVEL_BITS-1:0] thr_q, full_q, cs_q, sf_q, rs_q, sw_q;

	// controller state
	mode_e                 mode_q;
	logic [LEVEL_BITS-1:0] cur_q;
	logic                  flag_q;
	phase_e                phase_q;
	logic                  last_q;

	// latched input word
	logic [LEVEL_BITS-1:0] accel_q, regen_q;
	logic [1:0]            dir_q;
	logic                  brake_q, rline_q, charge_q, discharge_q;

	// per-tick working registers
	dec_t                  dec, dec_q;
	phase_e                phase_nx;
	logic [LEVEL_BITS-1:0] t_q;
	logic [LEVEL_BITS-1:0] cur_n_q;
	logic                  flag_clr_q;
	logic                  ge_q;

	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] motor_current_q;
	vel_e                  vel_q;
	mode_e                 mode_out_q;
	logic                  pulse_q;

	logic                  dir_fwd, dir_rev;
	logic                  pedal_on, full_gt;
	logic [LEVEL_BITS-1:0] pedal_top, num, den;
	logic                  t_ge;
	logic [LEVEL_BITS-1:0] sdiff, mstep, smoothed;
	logic                  commit;

	mul_req_t              mul_req;
	logic                  mul_done;
	logic [PROD_BITS-1:0]  mul_prod;
	div_req_t              div_req;
	logic                  div_done;
	logic [LEVEL_BITS-1:0] div_quot;

	pmdc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pmdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign dir_fwd = dir_q == 2'd1;
	assign dir_rev = dir_q == 2'd0;

	// mode machine decision for the latched word
	always_comb begin
		dec        = '0;
		dec.mode   = mode_q;
		dec.flag   = flag_q;
		dec.vel    = VEL_ZERO;
		dec.cur_sel = CUR_ZERO;
		phase_nx   = phase_q;
		if (!(dir_fwd || dir_rev)) begin
			dec.cur_sel = CUR_ZERO;
		end else if (phase_q == PH_SETTING) begin
			if (sw_q != '0)
				phase_nx = PH_RESETTING;
		end else if (regen_q > thr_q) begin
			dec.mode = MODE_REGEN;
			dec.flag = flag_q | (mode_q == MODE_ACCEL);
			if (dec.flag) begin
				if (sw_q != '0)
					dec.flag = 1'b0;
			end else if (charge_q) begin
				dec.cur_sel   = CUR_PEDAL;
				dec.pedal     = regen_q;
				dec.use_regen = 1'b1;
			end
		end else if (brake_q) begin
			dec.mode = MODE_MECH;
		end else if (accel_q > thr_q) begin
			dec.mode = MODE_ACCEL;
			dec.flag = flag_q | (mode_q == MODE_REGEN);
			if (dec.flag) begin
				if (accel_q < sw_q) begin
					dec.flag = 1'b0;
				end else begin
					dec.cur_sel = CUR_RAW;
					dec.pedal   = accel_q;
				end
			end else if (discharge_q) begin
				dec.vel     = dir_fwd ? VEL_FWD : VEL_REV;
				dec.cur_sel = CUR_PEDAL;
				dec.pedal   = accel_q;
			end else begin
				dec.mode = MODE_OFF;
			end
		end else begin
			dec.mode = MODE_OFF;
			dec.flag = flag_q | (mode_q == MODE_ACCEL);
			if (dec.flag) begin
				dec.cur_sel   = CUR_DECAY;
				dec.decay_chk = 1'b1;
			end
		end
		// press = falling edge of the active-low button
		if (last_q && !rline_q)
			phase_nx = PH_SETTING;
		dec.pulse = phase_nx == PH_RESETTING;
		dec.phase = (phase_nx == PH_SETTING) ? PH_SETTING : PH_IDLE;
	end

	// pedal to current operands
	assign pedal_on  = dec.pedal > thr_q;
	assign full_gt   = full_q > thr_q;
	assign pedal_top = (dec.pedal < full_q) ? dec.pedal : full_q;
	assign num       = pedal_top - thr_q;
	assign den       = full_q - thr_q;

	// low-pass step
	assign t_ge     = t_q >= cur_q;
	assign sdiff    = t_ge ? (t_q - cur_q) : (cur_q - t_q);
	assign mstep    = mul_prod[PROD_BITS-1:LEVEL_BITS];
	assign smoothed = ge_q ? (cur_q + mstep) : (cur_q - mstep);

	assign commit = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				unique case (dec.cur_sel)
					CUR_PEDAL: begin
						if (pedal_on && full_gt) begin
							mul_req.go = 1'b1;
							mul_req.a  = num;
							mul_req.b  = cs_q;
							state_d    = ST_PMUL;
						end else begin
							state_d = ST_TGT;
						end
					end
					CUR_DECAY: state_d = ST_SMOOTH;
					CUR_ZERO:  state_d = ST_FIN;
					CUR_RAW:   state_d = ST_FIN;
				endcase
			end
			ST_PMUL: begin
				if (mul_done) begin
					div_req.go       = 1'b1;
					div_req.dividend = mul_prod;
					div_req.den      = den;
					state_d          = ST_PDIV;
				end
			end
			ST_PDIV: begin
				if (div_done)
					state_d = ST_TGT;
			end
			ST_TGT: begin
				if (dec_q.use_regen) begin
					mul_req.go = 1'b1;
					mul_req.a  = t_q;
					mul_req.b  = rs_q;
					state_d    = ST_RMUL;
				end else begin
					state_d = ST_SMOOTH;
				end
			end
			ST_RMUL: begin
				if (mul_done)
					state_d = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				mul_req.go = 1'b1;
				mul_req.a  = sdiff;
				mul_req.b  = sf_q;
				state_d    = ST_SMUL;
			end
			ST_SMUL: begin
				if (mul_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state, tuning registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= RST_PEDAL_THRESHOLD;
			full_q      <= RST_PEDAL_FULL_SCALE;
			cs_q        <= RST_CURRENT_SCALE;
			sf_q        <= RST_SMOOTHING_FACTOR;
			rs_q        <= RST_REGEN_SCALE;
			sw_q        <= RST_SWITCHING_CURRENT;
			mode_q      <= MODE_OFF;
			cur_q       <= '0;
			flag_q      <= 1'b0;
			phase_q     <= PH_IDLE;
			last_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PEDAL_THRESHOLD:   thr_q  <= cfg_data;
					REG_PEDAL_FULL_SCALE:  full_q <= cfg_data;
					REG_CURRENT_SCALE:     cs_q   <= cfg_data;
					REG_SMOOTHING_FACTOR:  sf_q   <= cfg_data;
					REG_REGEN_SCALE:       rs_q   <= cfg_data;
					REG_SWITCHING_CURRENT: sw_q   <= cfg_data;
					default: ;
				endcase
			end
			if (commit) begin
				mode_q      <= dec_q.mode;
				cur_q       <= cur_n_q;
				flag_q      <= dec_q.flag & ~flag_clr_q;
				phase_q     <= dec_q.phase;
				last_q      <= rline_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			accel_q     <= accel_pedal;
			regen_q     <= regen_pedal;
			dir_q       <= direction_bits;
			brake_q     <= brake_line;
			rline_q     <= reset_line;
			charge_q    <= allow_charge;
			discharge_q <= allow_discharge;
		end
		if (state_q == ST_DECIDE) begin
			dec_q      <= dec;
			// pedal pressed with no span: full current scale
			t_q        <= pedal_on ? cs_q : '0;
			cur_n_q    <= (dec.cur_sel == CUR_RAW) ? dec.pedal : '0;
			flag_clr_q <= 1'b0;
		end
		if (state_q == ST_PDIV && div_done)
			t_q <= div_quot;
		if (state_q == ST_RMUL && mul_done)
			t_q <= mul_prod[PROD_BITS-1:LEVEL_BITS];
		if (state_q == ST_SMOOTH)
			ge_q <= t_ge;
		if (state_q == ST_SMUL && mul_done) begin
			// coasting down: switch completes once below switching current
			if (dec_q.decay_chk && smoothed < sw_q) begin
				cur_n_q    <= '0;
				flag_clr_q <= 1'b1;
			end else begin
				cur_n_q <= smoothed;
			end
		end
		if (commit) begin
			motor_current_q <= cur_n_q;
			vel_q           <= dec_q.vel;
			mode_out_q      <= dec_q.mode;
			pulse_q         <= dec_q.pulse;
		end
	end

	assign in_stall        = state_q != ST_IDLE;
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign motor_current   = motor_current_q;
	assign velocity_select = vel_q;
	assign drive_mode      = mode_out_q;
	assign send_reset      = pulse_q;

	`PMDC_ASSERT(a_vel_needs_accel, (out_valid && velocity_select != VEL_ZERO) |-> drive_mode == MODE_ACCEL, "velocity chosen outside accelerate mode")
	`PMDC_ASSERT(a_mech_zero_current, (out_valid && drive_mode == MODE_MECH) |-> motor_current == '0, "current commanded in mechanical brake mode")
	`PMDC_ASSERT(a_pulse_phase_idle, (out_valid && send_reset) |-> phase_q == PH_IDLE, "reset pulse left phase pending")
	`PMDC_ASSERT_NEXT(a_fin_commits, (state_q == ST_FIN && !(out_valid && out_stall)), out_valid && state_q == ST_IDLE, "finished word not committed")

endmodule

FILE: src/pmdc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle
module pmdc_mul
	import pmdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mul_req_t             req,
	output logic                 done,
	output logic [PROD_BITS-1:0] prod
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEVEL_BITS-1:0] a_q;
	logic [PROD_BITS-1:0]  p_q;
	logic [LEVEL_BITS:0]   sum;

	// low half holds the unused multiplier bits, high half the partial sum
	assign sum = {1'b0, p_q[PROD_BITS-1:LEVEL_BITS]} +
		{1'b0, a_q & {LEVEL_BITS{p_q[0]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			p_q <= {{LEVEL_BITS{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[LEVEL_BITS-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

FILE: src/pmdc_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit LEVEL_BITS
module pmdc_div
	import pmdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	output logic                  done,
	output logic [LEVEL_BITS-1:0] quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEVEL_BITS-1:0] den_q;
	logic [LEVEL_BITS-1:0] rem_q;
	logic [LEVEL_BITS-1:0] low_q;
	logic [LEVEL_BITS-1:0] quot_q;
	logic [LEVEL_BITS:0]   trial;
	logic [LEVEL_BITS:0]   diff;
	logic                  ge;

	assign trial = {rem_q, low_q[LEVEL_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			den_q  <= req.den;
			rem_q  <= req.dividend[PROD_BITS-1:LEVEL_BITS];
			low_q  <= req.dividend[LEVEL_BITS-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[LEVEL_BITS-1:0] : trial[LEVEL_BITS-1:0];
			low_q  <= {low_q[LEVEL_BITS-2:0], 1'b0};
			quot_q <= {quot_q[LEVEL_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
